// File: sv/spm_pkg.sv
// ----------------------------------------------------------------------------
// spm_pkg: shared definitions for the spectrum peak merge block
// Sizes of the peak table, the transfer payload structs, operation codes,
// register indexes and controller states.
// ----------------------------------------------------------------------------
`default_nettype none

package spm_pkg;

    // Table geometry.
    localparam int MAX_PEAKS  = 64;
    localparam int MZ_BITS    = 32;
    localparam int IDX_W      = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
    localparam int CNT_W      = $clog2(MAX_PEAKS + 1);

    // Field widths of the transfers.
    localparam int FIELD_MZ_W  = 32;
    localparam int INT_W       = 32;
    localparam int RES_IDX_W   = 6;
    localparam int TOL_W       = 20;

    // Stored m/z keeps the low MZ_BITS bits of the 32-bit input field.
    localparam int STORE_MZ_W = (MZ_BITS < FIELD_MZ_W) ? MZ_BITS : FIELD_MZ_W;
    localparam int MEM_W      = STORE_MZ_W + INT_W;
    localparam int CMP_W      = (STORE_MZ_W > TOL_W) ? STORE_MZ_W : TOL_W;

    // Configuration port.
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;
    localparam int REG_IDX_W = PADDR_W - 2;
    localparam logic [REG_IDX_W-1:0] REG_MZ_TOLERANCE = 1'b0;
    localparam logic [TOL_W-1:0]     TOL_RESET        = 20'd100;

    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_LOAD  = 2'd1,
        OP_MERGE = 2'd2,
        OP_DUMP  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_DUMP
    } state_t;

    typedef struct packed {
        op_t                   op;
        logic [FIELD_MZ_W-1:0] peak_mz;
        logic [INT_W-1:0]      peak_intensity;
    } item_t;

    typedef struct packed {
        logic [FIELD_MZ_W-1:0] out_mz;
        logic [INT_W-1:0]      out_intensity;
        logic [RES_IDX_W-1:0]  entry_index;
        logic                  entry_valid;
        logic                  was_appended;
        logic                  was_raised;
        logic                  was_dropped;
        logic                  last;
    } result_t;

endpackage

`default_nettype wire

// File: sv/spm_ram.sv
// ----------------------------------------------------------------------------
// spm_ram: generic single-write, single-read synchronous RAM
// One write port and one read port; read data is registered, so it appears
// in the cycle after the address.
// ----------------------------------------------------------------------------
`default_nettype none

module spm_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output      logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// File: sv/spectrum_peak_merge_keep_max.sv
// ----------------------------------------------------------------------------
// spectrum_peak_merge_keep_max: peak table with merge that keeps max intensity
// Clear, load, merge and dump operations on a table of m/z and intensity
// pairs held in one synchronous RAM, with a register port for the tolerance.
// ----------------------------------------------------------------------------
//
//   Channel   Handshake             Payload    Moves
//   --------  --------------------  ---------  ------------------------------
//   item      item_valid/item_ready item_t     one operation per transfer
//   result    result_valid/_ready   result_t   one or more results per item
//   config    psel/penable/pwrite   pwdata     mz_tolerance, address 0
//
// An item is taken only while the controller is idle and sits in an input
// register until the next cycle, when it executes. A merge with nothing
// loaded appends at once; else it reads table entries, one RAM read per
// cycle, until the first match (or all entries). A dump gives one result
// per entry, or a single all-zero result when the table is empty.
// Each result is placed in an output register; the controller stalls only
// when that register is still full, and it accepts the next item while the
// last result waits. Reset empties the table at once through the counters;
// the RAM itself needs no clearing because only entries below the count are
// ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_peak_merge_keep_max
    import spm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,

    input  wire logic               item_valid,
    output      logic               item_ready,
    input  wire item_t              item,

    output      logic               result_valid,
    input  wire logic               result_ready,
    output      result_t            result,

    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output      logic [PDATA_W-1:0] prdata,
    output      logic               pready
);

    // Controller state and counters.
    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [CNT_W-1:0]     loaded_reg, loaded_next;
    logic [TOL_W-1:0]     tol_reg;
    item_t                item_reg;

    // Output register.
    logic                 res_valid_reg, res_valid_next;
    result_t              res_reg, res_next;

    // RAM ports.
    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [MEM_W-1:0]     ram_wdata;
    logic [IDX_W-1:0]     ram_raddr;
    logic [MEM_W-1:0]     ram_rdata;

    // Datapath.
    logic                  can_put;
    logic                  put;
    logic                  do_append;
    logic [STORE_MZ_W-1:0] item_mz;
    logic [STORE_MZ_W-1:0] stored_mz;
    logic [INT_W-1:0]      stored_int;
    logic [STORE_MZ_W-1:0] abs_diff;
    logic                  hit;
    logic                  raised;
    logic                  scan_last;
    logic                  table_full;
    logic [REG_IDX_W-1:0]  reg_idx;
    logic                  cfg_write;

    // ------------------------------------------------------------------
    // Configuration port. Writes complete in the access phase; pready is
    // tied high so there are no wait states.
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign reg_idx   = paddr[PADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_write && (reg_idx == REG_MZ_TOLERANCE))
        begin
            tol_reg <= pwdata[TOL_W-1:0];
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_MZ_TOLERANCE)
        begin
            prdata = PDATA_W'(tol_reg);
        end
    end

    // ------------------------------------------------------------------
    // Peak table: each word holds the m/z in the upper part and the
    // intensity in the lower 32 bits.
    // ------------------------------------------------------------------
    spm_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MAX_PEAKS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Compare of the entry read last cycle against the held peak.
    // ------------------------------------------------------------------
    assign item_mz    = item_reg.peak_mz[STORE_MZ_W-1:0];
    assign stored_mz  = ram_rdata[MEM_W-1:INT_W];
    assign stored_int = ram_rdata[INT_W-1:0];
    assign abs_diff   = (stored_mz > item_mz) ? (stored_mz - item_mz)
                                              : (item_mz - stored_mz);
    assign hit        = CMP_W'(abs_diff) <= CMP_W'(tol_reg);
    assign raised     = item_reg.peak_intensity > stored_int;
    assign scan_last  = (CNT_W'(idx_reg) + CNT_W'(1)) == cnt_reg;
    assign table_full = cnt_reg == CNT_W'(MAX_PEAKS);

    // A result may be placed when the output register is empty or is
    // being drained in this cycle.
    assign can_put    = !res_valid_reg || result_ready;
    assign item_ready = state_reg == ST_IDLE;

    // ------------------------------------------------------------------
    // Controller.
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        loaded_next = loaded_reg;
        res_next    = res_reg;
        put         = 1'b0;
        do_append   = 1'b0;
        ram_we      = 1'b0;
        ram_waddr   = cnt_reg[IDX_W-1:0];
        ram_wdata   = {item_mz, item_reg.peak_intensity};
        // Holding the address keeps the read data steady during a stall.
        ram_raddr   = idx_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                ram_raddr = '0;
                idx_next  = '0;
                case (item_reg.op)
                    OP_CLEAR:
                    begin
                        if (can_put)
                        begin
                            put         = 1'b1;
                            res_next    = '0;
                            res_next.last = 1'b1;
                            cnt_next    = '0;
                            loaded_next = '0;
                            state_next  = ST_IDLE;
                        end
                    end
                    OP_LOAD:
                    begin
                        if (can_put)
                        begin
                            do_append  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                    OP_MERGE:
                    begin
                        // With nothing loaded the peak goes straight in.
                        if (loaded_reg == '0)
                        begin
                            if (can_put)
                            begin
                                do_append  = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = ST_SCAN;
                        end
                    end
                    OP_DUMP:
                    begin
                        if (cnt_reg == '0)
                        begin
                            if (can_put)
                            begin
                                put           = 1'b1;
                                res_next      = '0;
                                res_next.last = 1'b1;
                                state_next    = ST_IDLE;
                            end
                        end
                        else
                        begin
                            state_next = ST_DUMP;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end

            ST_SCAN:
            begin
                if (hit)
                begin
                    if (can_put)
                    begin
                        put                    = 1'b1;
                        res_next.out_mz        = FIELD_MZ_W'(stored_mz);
                        res_next.out_intensity = raised ? item_reg.peak_intensity
                                                        : stored_int;
                        res_next.entry_index   = RES_IDX_W'(idx_reg);
                        res_next.entry_valid   = 1'b1;
                        res_next.was_appended  = 1'b0;
                        res_next.was_raised    = raised;
                        res_next.was_dropped   = 1'b0;
                        res_next.last          = 1'b1;
                        ram_we                 = raised;
                        ram_waddr              = idx_reg;
                        ram_wdata              = {stored_mz, item_reg.peak_intensity};
                        state_next             = ST_IDLE;
                    end
                end
                else if (!scan_last)
                begin
                    idx_next  = idx_reg + IDX_W'(1);
                    ram_raddr = idx_reg + IDX_W'(1);
                end
                else if (can_put)
                begin
                    do_append  = 1'b1;
                    state_next = ST_IDLE;
                end
            end

            ST_DUMP:
            begin
                if (can_put)
                begin
                    put                    = 1'b1;
                    res_next.out_mz        = FIELD_MZ_W'(stored_mz);
                    res_next.out_intensity = stored_int;
                    res_next.entry_index   = RES_IDX_W'(idx_reg);
                    res_next.entry_valid   = 1'b1;
                    res_next.was_appended  = 1'b0;
                    res_next.was_raised    = 1'b0;
                    res_next.was_dropped   = 1'b0;
                    res_next.last          = scan_last;
                    if (scan_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next  = idx_reg + IDX_W'(1);
                        ram_raddr = idx_reg + IDX_W'(1);
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Append of the held peak at the end of the table, shared by load, by a
        // merge with nothing loaded and by a merge that found no match. A full
        // table drops the peak and echoes it back.
        if (do_append)
        begin
            put                    = 1'b1;
            res_next.out_mz        = FIELD_MZ_W'(item_mz);
            res_next.out_intensity = item_reg.peak_intensity;
            res_next.was_raised    = 1'b0;
            res_next.last          = 1'b1;
            if (table_full)
            begin
                res_next.entry_index  = '0;
                res_next.entry_valid  = 1'b0;
                res_next.was_appended = 1'b0;
                res_next.was_dropped  = 1'b1;
            end
            else
            begin
                ram_we                = 1'b1;
                ram_waddr             = cnt_reg[IDX_W-1:0];
                res_next.entry_index  = RES_IDX_W'(cnt_reg[IDX_W-1:0]);
                res_next.entry_valid  = 1'b1;
                res_next.was_appended = 1'b1;
                res_next.was_dropped  = 1'b0;
                cnt_next              = cnt_reg + CNT_W'(1);
                if (item_reg.op == OP_LOAD)
                begin
                    loaded_next = loaded_reg + CNT_W'(1);
                end
            end
        end

        res_valid_next = put || (res_valid_reg && !result_ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            loaded_reg    <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            loaded_reg    <= loaded_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            item_reg <= item;
        end
        if (put)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

// File: test/spectrum_peak_merge_keep_max_tb.sv
// ----------------------------------------------------------------------------
// spectrum_peak_merge_keep_max_tb: self-checking bench for the peak merge block
// A short table of directed operations is followed by random spectrum
// sessions (clear, loads, merges, dumps, some noise) under several tolerance
// settings. Every result transfer is checked field by field against a
// behavioral copy of the peak table that runs inside the bench.
// ----------------------------------------------------------------------------
`default_nettype none

module spectrum_peak_merge_keep_max_tb;

    import spm_pkg::*;

    // Run shape. The item target covers the directed table and the random
    // sessions; the cycle limit sits well above the slowest legal run.
    localparam int ITEM_TARGET     = 260;
    localparam int CYCLE_LIMIT     = 1000000;
    localparam int DRAIN_CYCLES    = MAX_PEAKS + 16;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PRINT_LIMIT     = 40;
    localparam int PHASES          = 5;

    // Register index with nothing behind it; writes to it must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_UNUSED = REG_MZ_TOLERANCE + 1'b1;

    // One entry of the outgoing item queue. When typed is set, res is the
    // single result that the row expects, written down by hand.
    typedef struct packed {
        item_t   it;
        logic    typed;
        result_t res;
    } queued_item_t;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    item_t              item;
    logic               result_valid;
    logic               result_ready;
    result_t            result;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    // Bench-side copy of the peak table and the tolerance register.
    logic [STORE_MZ_W-1:0] held_mz        [MAX_PEAKS];
    logic [INT_W-1:0]      held_intensity [MAX_PEAKS];
    int                    peaks_held;
    int                    peaks_loaded;
    logic [TOL_W-1:0]      tol_window;

    queued_item_t outgoing_items[$];
    result_t      pending_peak_results[$];

    int mismatch_count;
    int items_offered;
    int cycle_count;
    int tx_idle_odds;
    int rx_stall_odds;
    bit quiet;
    bit hold_off_req;

    spectrum_peak_merge_keep_max DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Helpers for building items and results
    // ------------------------------------------------------------------------

    function automatic item_t make_item(op_t op, logic [FIELD_MZ_W-1:0] mz,
                                        logic [INT_W-1:0] intensity);
        item_t r;
        r.op             = op;
        r.peak_mz        = mz;
        r.peak_intensity = intensity;
        return r;
    endfunction

    function automatic result_t make_result(logic [FIELD_MZ_W-1:0] mz,
                                            logic [INT_W-1:0] intensity,
                                            int idx, bit valid, bit appended,
                                            bit raised, bit dropped, bit last);
        result_t r;
        r.out_mz        = mz;
        r.out_intensity = intensity;
        r.entry_index   = RES_IDX_W'(idx);
        r.entry_valid   = valid;
        r.was_appended  = appended;
        r.was_raised    = raised;
        r.was_dropped   = dropped;
        r.last          = last;
        return r;
    endfunction

    // Adds one result to the end of the list of results still owed.
    function automatic void owe_result(result_t r);
        pending_peak_results.insert(pending_peak_results.size(), r);
    endfunction

    // ------------------------------------------------------------------------
    // Peak table predictor
    // ------------------------------------------------------------------------

    // Places a peak at the end of the table, or reports it as dropped when
    // every slot is taken. Only loads count toward the loaded total.
    function automatic void append_peak(logic [STORE_MZ_W-1:0] mz,
                                        logic [INT_W-1:0] intensity, bit is_load);
        if (peaks_held >= MAX_PEAKS)
        begin
            owe_result(make_result(mz, intensity, 0, 0, 0, 0, 1, 1));
            return;
        end
        held_mz[peaks_held]        = mz;
        held_intensity[peaks_held] = intensity;
        owe_result(make_result(mz, intensity, peaks_held, 1, 1, 0, 0, 1));
        peaks_held++;
        if (is_load)
            peaks_loaded++;
    endfunction

    // Applies one accepted item to the bench table and queues every result
    // that the block owes for it.
    function automatic void predict_peak_table(item_t it);
        logic [STORE_MZ_W-1:0] mz;
        logic [63:0]           mz_gap;
        bit                    matched;
        bit                    raised;
        int                    i;
        mz      = it.peak_mz[STORE_MZ_W-1:0];
        matched = 1'b0;
        case (it.op)
            OP_CLEAR:
            begin
                peaks_held   = 0;
                peaks_loaded = 0;
                owe_result(make_result(0, 0, 0, 0, 0, 0, 0, 1));
            end
            OP_LOAD:
                append_peak(mz, it.peak_intensity, 1'b1);
            OP_MERGE:
            begin
                // With nothing loaded since the last clear the search is
                // skipped, even when an earlier merged peak lies close by.
                if (peaks_loaded != 0)
                begin
                    for (i = 0; i < peaks_held && !matched; i++)
                    begin
                        mz_gap = (held_mz[i] > mz) ? held_mz[i] - mz : mz - held_mz[i];
                        if (mz_gap <= tol_window)
                        begin
                            raised = it.peak_intensity > held_intensity[i];
                            if (raised)
                                held_intensity[i] = it.peak_intensity;
                            owe_result(make_result(held_mz[i],
                                held_intensity[i], i, 1, 0, raised, 0, 1));
                            matched = 1'b1;
                        end
                    end
                end
                if (!matched)
                    append_peak(mz, it.peak_intensity, 1'b0);
            end
            default:
            begin
                if (peaks_held == 0)
                    owe_result(make_result(0, 0, 0, 0, 0, 0, 0, 1));
                for (i = 0; i < peaks_held; i++)
                    owe_result(make_result(held_mz[i],
                        held_intensity[i], i, 1, 0, 0, 0, i + 1 == peaks_held));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH %s: got %0h, want %0h (cycle %0d)", what, got, want,
                     cycle_count);
    endtask

    task automatic check_result(result_t got);
        result_t want;
        if (pending_peak_results.size() == 0)
        begin
            report_mismatch("result transfer with nothing pending", 64'(got), 64'(0));
            return;
        end
        want = pending_peak_results.pop_front();
        if (got.out_mz !== want.out_mz)
            report_mismatch("out_mz", 64'(got.out_mz), 64'(want.out_mz));
        if (got.out_intensity !== want.out_intensity)
            report_mismatch("out_intensity", 64'(got.out_intensity),
                            64'(want.out_intensity));
        if (got.entry_index !== want.entry_index)
            report_mismatch("entry_index", 64'(got.entry_index), 64'(want.entry_index));
        if (got.entry_valid !== want.entry_valid)
            report_mismatch("entry_valid", 64'(got.entry_valid), 64'(want.entry_valid));
        if (got.was_appended !== want.was_appended)
            report_mismatch("was_appended", 64'(got.was_appended),
                            64'(want.was_appended));
        if (got.was_raised !== want.was_raised)
            report_mismatch("was_raised", 64'(got.was_raised), 64'(want.was_raised));
        if (got.was_dropped !== want.was_dropped)
            report_mismatch("was_dropped", 64'(got.was_dropped), 64'(want.was_dropped));
        if (got.last !== want.last)
            report_mismatch("last", 64'(got.last), 64'(want.last));
    endtask

    // Values are taken as they stood just before the edge, so the check does
    // not depend on how the block's own updates are ordered in that step.
    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            check_result(result);
    end

    // ------------------------------------------------------------------------
    // Item sender
    // ------------------------------------------------------------------------

    // The sender takes items from the outgoing queue, holds each one with
    // valid high until the transfer, and runs the predictor at the edge of
    // the transfer. Once the queue runs dry, valid drops.
    initial
    begin
        int issued_before;
        item_valid = 1'b0;
        item       = '0;
        wait (rst_n);
        forever
        begin
            if (outgoing_items.size() == 0)
            begin
                item_valid = 1'b0;
                @(negedge clk);
            end
            else
            begin
                if (!quiet && tx_idle_odds != 0 && $urandom_range(1, tx_idle_odds) == 1)
                begin
                    item_valid = 1'b0;
                    repeat ($urandom_range(1, 12)) @(negedge clk);
                end
                item       = outgoing_items[0].it;
                item_valid = 1'b1;
                do
                    @(posedge clk);
                while (!item_ready);
                issued_before = pending_peak_results.size();
                predict_peak_table(outgoing_items[0].it);
                // A hand-written row replaces what the predictor queued, while
                // the predictor still tracks the table.
                if (outgoing_items[0].typed)
                begin
                    while (pending_peak_results.size() > issued_before)
                        void'(pending_peak_results.pop_back());
                    owe_result(outgoing_items[0].res);
                end
                void'(outgoing_items.pop_front());
                @(negedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver
    // ------------------------------------------------------------------------

    // Ready stalls come in short random bursts. A hold-off request closes
    // ready for a long stretch so that the block backs up into its input.
    initial
    begin
        int stall_left;
        stall_left   = 0;
        result_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                result_ready = 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
                result_ready = 1'b1;
            end
            else if (stall_left > 0)
            begin
                result_ready = 1'b0;
                stall_left--;
            end
            else if (!quiet && rx_stall_odds != 0 && $urandom_range(1, rx_stall_odds) == 1)
            begin
                result_ready = 1'b0;
                stall_left   = $urandom_range(0, 11);
            end
            else
                result_ready = 1'b1;
        end
    end

    // The run is cut off if it ever takes far longer than a correct block
    // could need.
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Stimulus tasks
    // ------------------------------------------------------------------------

    // Keeps at most two items queued ahead of the sender, so the sender
    // always has the next one in hand and back-to-back transfers stay
    // possible.
    task automatic queue_item(item_t it, logic typed, result_t res);
        queued_item_t q;
        while (outgoing_items.size() >= 2)
            @(negedge clk);
        q.it    = it;
        q.typed = typed;
        q.res   = res;
        outgoing_items.insert(outgoing_items.size(), q);
        items_offered++;
    endtask

    // Waits until every item has gone out and every result has come back,
    // then lets the block settle before the caller touches the register.
    task automatic wait_for_drain();
        while (outgoing_items.size() != 0 || pending_peak_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    // One APB transfer: a setup cycle, then an access cycle that completes on
    // the edge where pready is high. Reads of the tolerance are checked.
    task automatic register_access(logic write, logic [REG_IDX_W-1:0] idx,
                                   logic [PDATA_W-1:0] data);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = write;
        paddr   = {idx, 2'b00};
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (write && idx == REG_MZ_TOLERANCE)
            tol_window = data[TOL_W-1:0];
        if (!write && idx == REG_MZ_TOLERANCE && prdata !== PDATA_W'(tol_window))
            report_mismatch("mz_tolerance read", 64'(prdata), 64'(tol_window));
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    function automatic logic [INT_W-1:0] pick_intensity();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return INT_W'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    // One spectrum session: usually a clear, a run of first-spectrum loads,
    // then second-spectrum merges that mostly land near stored peaks, with
    // dumps and a sprinkle of random noise items. Some sessions skip the
    // clear or the loads, which breaks the usual order on purpose. A fill
    // session loads at least the table size so that peaks get dropped.
    task automatic run_session(bit fill_table);
        logic [FIELD_MZ_W-1:0] base_mz;
        logic [FIELD_MZ_W-1:0] mz;
        logic [31:0]           span;
        int                    n_load;
        int                    n_merge;
        int                    offset;
        int                    k;
        tx_idle_odds  = quiet ? 0 : 2 * $urandom_range(0, 4);
        rx_stall_odds = quiet ? 0 : 2 * $urandom_range(0, 4);
        base_mz = $urandom();
        span    = (32'(tol_window) + 1) * 8;
        if (fill_table)
            n_load = $urandom_range(MAX_PEAKS, MAX_PEAKS + 6);
        else if ($urandom_range(0, 7) == 0)
            n_load = 0;
        else
            n_load = $urandom_range(1, 12);
        n_merge = $urandom_range(1, 16);

        if ($urandom_range(0, 5) != 0)
            queue_item(make_item(OP_CLEAR, $urandom(), $urandom()), 1'b0, '0);
        for (k = 0; k < n_load; k++)
        begin
            mz = ($urandom_range(0, 7) == 0) ? $urandom() : base_mz + $urandom_range(0, span);
            queue_item(make_item(OP_LOAD, mz, pick_intensity()), 1'b0, '0);
        end
        for (k = 0; k < n_merge; k++)
        begin
            if ($urandom_range(0, 9) == 0)
                queue_item(make_item(op_t'($urandom_range(0, 3)), $urandom(), $urandom()),
                           1'b0, '0);
            else
            begin
                // Near a stored peak, just inside or just outside the window.
                if (peaks_held > 0 && $urandom_range(0, 2) != 0)
                begin
                    offset = $urandom_range(0, 2 * int'(tol_window) + 4);
                    mz = FIELD_MZ_W'(held_mz[$urandom_range(0, peaks_held - 1)])
                         + FIELD_MZ_W'(offset) - FIELD_MZ_W'(tol_window) - 2;
                end
                else
                    mz = base_mz + $urandom_range(0, span);
                queue_item(make_item(OP_MERGE, mz, pick_intensity()), 1'b0, '0);
            end
            if ($urandom_range(0, 11) == 0)
                queue_item(make_item(OP_DUMP, $urandom(), $urandom()), 1'b0, '0);
        end
        if ($urandom_range(0, 3) != 0)
            queue_item(make_item(OP_DUMP, $urandom(), $urandom()), 1'b0, '0);
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        queued_item_t directed_rows[$];
        queued_item_t row;
        int           phase;
        int           budget;
        int           rows_done;
        bit           fill_pending;
        logic [TOL_W-1:0] new_tol;

        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        quiet          = 1'b0;
        hold_off_req   = 1'b0;
        tx_idle_odds   = 0;
        rx_stall_odds  = 0;
        mismatch_count = 0;
        items_offered  = 0;
        peaks_held     = 0;
        peaks_loaded   = 0;
        tol_window     = TOL_RESET;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // The tolerance must read back its reset value before any write.
        register_access(1'b0, REG_MZ_TOLERANCE, '0);

        // Directed table, at the reset tolerance of 0.001 Da. Rows whose
        // outcome is plain from the rules carry it; two of the dumps and one
        // append are left to the predictor.
        row.typed = 1'b1;
        // Dump of an empty table gives a single all-zero result with last.
        row.it = make_item(OP_DUMP, '0, '0);
        row.res = make_result(0, 0, 0, 0, 0, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        // Merges before any load append without searching, even when close.
        row.it = make_item(OP_MERGE, 1000, 5);
        row.res = make_result(1000, 5, 0, 1, 1, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        row.it = make_item(OP_MERGE, 1050, 7);
        row.res = make_result(1050, 7, 1, 1, 1, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        // Loads after merges still append, at both field extremes.
        row.it = make_item(OP_LOAD, '0, '0);
        row.res = make_result(0, 0, 2, 1, 1, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        row.it = make_item(OP_LOAD, '1, '1);
        row.res = make_result('1, '1, 3, 1, 1, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        // Match with a larger intensity raises the entry.
        row.it = make_item(OP_MERGE, 1020, 9);
        row.res = make_result(1000, 9, 0, 1, 0, 1, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        // An equal intensity leaves the entry as it is.
        row.it = make_item(OP_MERGE, 1020, 9);
        row.res = make_result(1000, 9, 0, 1, 0, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        // Exactly at the tolerance counts as a match.
        row.it = make_item(OP_MERGE, 100, 3);
        row.res = make_result(0, 3, 2, 1, 0, 1, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        // One unit beyond the tolerance appends.
        row.it = make_item(OP_MERGE, 101, 1);
        row.res = make_result(101, 1, 4, 1, 1, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        // Top of the m/z range, smaller intensity: matched, not raised.
        row.it = make_item(OP_MERGE, 32'hFFFF_FF9B, 0);
        row.res = make_result('1, '1, 3, 1, 0, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        row.typed = 1'b0;
        row.res   = '0;
        row.it = make_item(OP_DUMP, '1, '1);
        directed_rows.insert(directed_rows.size(), row);
        row.typed = 1'b1;
        // Clear ignores its payload and answers with an all-zero result.
        row.it = make_item(OP_CLEAR, '1, '1);
        row.res = make_result(0, 0, 0, 0, 0, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        row.it = make_item(OP_DUMP, '0, '0);
        directed_rows.insert(directed_rows.size(), row);
        // After a clear the loaded count is back at zero.
        row.it = make_item(OP_MERGE, 500, 1);
        row.res = make_result(500, 1, 0, 1, 1, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        row.it = make_item(OP_MERGE, 500, 2);
        row.res = make_result(500, 2, 1, 1, 1, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        row.it = make_item(OP_LOAD, 500, 3);
        row.res = make_result(500, 3, 2, 1, 1, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        // Several entries match; only the first in table order is touched.
        row.it = make_item(OP_MERGE, 550, 10);
        row.res = make_result(500, 10, 0, 1, 0, 1, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        row.it = make_item(OP_MERGE, 400, '1);
        row.res = make_result(500, '1, 0, 1, 0, 1, 0, 1);
        directed_rows.insert(directed_rows.size(), row);
        row.typed = 1'b0;
        row.res   = '0;
        row.it = make_item(OP_MERGE, 601, 0);
        directed_rows.insert(directed_rows.size(), row);
        row.it = make_item(OP_DUMP, '0, '1);
        directed_rows.insert(directed_rows.size(), row);
        row.typed = 1'b1;
        row.it = make_item(OP_CLEAR, '0, '0);
        row.res = make_result(0, 0, 0, 0, 0, 0, 0, 1);
        directed_rows.insert(directed_rows.size(), row);

        foreach (directed_rows[i])
            queue_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].res);
        rows_done = items_offered;

        // Random part, one tolerance setting per phase. The register is only
        // written once the block has gone quiet.
        fill_pending = 1'b1;
        for (phase = 0; phase < PHASES; phase++)
        begin
            wait_for_drain();
            case (phase)
                0: new_tol = '0;
                1: new_tol = '1;
                2: new_tol = TOL_W'($urandom_range(1, 3000));
                3: new_tol = TOL_W'($urandom_range(0, 200000));
                default: new_tol = TOL_RESET;
            endcase
            // A write to the empty index must leave the tolerance alone.
            if (phase == 3)
                register_access(1'b1, REG_UNUSED, $urandom());
            register_access(1'b1, REG_MZ_TOLERANCE,
                            {(PDATA_W - TOL_W)'($urandom()), new_tol});
            register_access(1'b0, REG_MZ_TOLERANCE, '0);
            // The last phase runs with no idling on either side.
            quiet  = (phase == PHASES - 1);
            budget = rows_done + (ITEM_TARGET - rows_done) * (phase + 1) / PHASES;
            while (items_offered < budget)
            begin
                // In the middle phase, fill the table past its size while
                // the receiver holds off for a long stretch.
                if (phase == 2 && fill_pending)
                begin
                    hold_off_req = 1'b1;
                    run_session(1'b1);
                    fill_pending = 1'b0;
                end
                else
                    run_session(1'b0);
            end
        end

        wait_for_drain();
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
